// File: rtl/rc4_stream_cipher_macros.svh
// Assertion macros for the RC4 stream cipher block.
// Define NO_ASSERTIONS to compile every check away.
`ifndef RC4_STREAM_CIPHER_MACROS_SVH
`define RC4_STREAM_CIPHER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RC4_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rc4 check failed");
`define RC4_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rc4 check failed");
`else
`define RC4_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define RC4_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
// No dependencies.
package rc4_pkg;

  typedef logic [7:0] byte_t;

  localparam int SBOX_DEPTH = 256;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int KEY_LEN_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd16;

  typedef enum logic [1:0] {
    RD_KEEP,
    RD_INC,
    RD_J,
    RD_K
  } rd_sel_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    logic    step_i;
    logic    take_j;
    logic    ksa;
    logic    take_b;
    logic    wr_j;
    logic    load_out;
    logic    cap_in;
    logic    clr_valid;
    logic    ksa_init;
    logic    idx_zero;
  } cmd_t;

  typedef struct packed {
    logic ksa_last;
  } stat_t;

endpackage

// File: rtl/rc4_sbox.sv
// Permutation memory with per-entry valid bits; an invalid entry reads as its address.
// One write port, one registered read port with write bypass. Uses rc4_pkg.
module rc4_sbox (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          we,
  input  rc4_pkg::byte_t waddr,
  input  rc4_pkg::byte_t wdata,
  input  rc4_pkg::byte_t raddr,
  output rc4_pkg::byte_t rdata
);

  rc4_pkg::byte_t mem [rc4_pkg::SBOX_DEPTH];
  logic [rc4_pkg::SBOX_DEPTH-1:0] vld_r;

  rc4_pkg::byte_t mem_q_r;
  rc4_pkg::byte_t addr_q_r;
  rc4_pkg::byte_t byp_data_r;
  logic           byp_r;
  logic           vld_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    addr_q_r   <= raddr;
    vld_q_r    <= vld_r[raddr];
    byp_r      <= we && (waddr == raddr);
    byp_data_r <= wdata;
  end

  assign rdata = byp_r ? byp_data_r : (vld_q_r ? mem_q_r : addr_q_r);

endmodule

// File: rtl/rc4_dp.sv
// Datapath: key and length registers, indices, swap operands and output register.
// Instantiates rc4_sbox; uses rc4_pkg.
module rc4_dp #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  rc4_pkg::byte_t                   in_data_byte,
  output rc4_pkg::byte_t                   out_byte,
  input  rc4_pkg::cmd_t                    cmd,
  output rc4_pkg::stat_t                   stat
);

  localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [rc4_pkg::KEY_LEN_W-1:0] MAX_LEN = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);

  rc4_pkg::byte_t key_r [MAX_KEY_BYTES];
  logic [rc4_pkg::KEY_LEN_W-1:0] len_r;
  logic [KIW-1:0] kidx_r;

  rc4_pkg::byte_t i_r, j_r, a_r, data_r, out_byte_r, raddr_r;
  logic           eqj_r;

  rc4_pkg::byte_t rdata, raddr, waddr, wdata, j_nxt, ks_addr, ks, key_b;
  logic           we;
  logic [rc4_pkg::KEY_LEN_W-1:0] used_len, kidx_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < MAX_KEY_BYTES; b++) begin
        key_r[b] <= '0;
      end
      len_r <= rc4_pkg::KEY_LEN_RESET;
    end else if (cfg_wr_en) begin
      for (int b = 0; b < MAX_KEY_BYTES; b++) begin
        if ((b < 8) ? (cfg_index == rc4_pkg::CFG_KEY_LOW)
                    : (cfg_index == rc4_pkg::CFG_KEY_HIGH)) begin
          key_r[b] <= cfg_data[8*(b%8) +: 8];
        end
      end
      if (cfg_index == rc4_pkg::CFG_KEY_LEN) begin
        len_r <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
      end
    end
  end

  always_comb begin
    if (len_r == '0) begin
      used_len = rc4_pkg::KEY_LEN_W'(1);
    end else if (len_r > MAX_LEN) begin
      used_len = MAX_LEN;
    end else begin
      used_len = len_r;
    end
  end

  assign kidx_inc = rc4_pkg::KEY_LEN_W'(kidx_r) + rc4_pkg::KEY_LEN_W'(1);
  assign key_b    = key_r[kidx_r];
  assign j_nxt    = j_r + rdata + (cmd.ksa ? key_b : 8'd0);
  assign ks_addr  = a_r + rdata;
  assign ks       = eqj_r ? a_r : rdata;

  always_comb begin
    case (cmd.rd_sel)
      rc4_pkg::RD_INC: raddr = i_r + 8'd1;
      rc4_pkg::RD_J:   raddr = j_nxt;
      rc4_pkg::RD_K:   raddr = ks_addr;
      default:         raddr = raddr_r;
    endcase
  end

  assign we    = cmd.take_b | cmd.wr_j;
  assign waddr = cmd.take_b ? i_r : j_r;
  assign wdata = cmd.take_b ? rdata : a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r     <= '0;
      j_r     <= '0;
      kidx_r  <= '0;
      raddr_r <= '0;
    end else begin
      raddr_r <= raddr;
      if (cmd.ksa_init) begin
        i_r    <= 8'hFF;
        j_r    <= '0;
        kidx_r <= '0;
      end else if (cmd.idx_zero) begin
        i_r <= '0;
        j_r <= '0;
      end else begin
        if (cmd.step_i) begin
          i_r <= i_r + 8'd1;
        end
        if (cmd.take_j) begin
          j_r <= j_nxt;
        end
        if (cmd.take_j && cmd.ksa) begin
          kidx_r <= (kidx_inc >= used_len) ? '0 : KIW'(kidx_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_j) begin
      a_r <= rdata;
    end
    if (cmd.take_b) begin
      eqj_r <= (ks_addr == j_r);
    end
    if (cmd.cap_in) begin
      data_r <= in_data_byte;
    end
    if (cmd.load_out) begin
      out_byte_r <= data_r ^ ks;
    end
  end

  rc4_sbox u_sbox (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (cmd.clr_valid),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign stat.ksa_last = (i_r == 8'hFF);
  assign out_byte      = out_byte_r;

endmodule

// File: rtl/rc4_ctrl.sv
// Controller: sequences key scheduling and per-beat keystream steps, owns handshakes.
// Uses rc4_pkg command and status types.
module rc4_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_message_start,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output rc4_pkg::cmd_t  cmd,
  input  rc4_pkg::stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_J,
    ST_RD_K,
    ST_WB,
    ST_K_CLR,
    ST_K_RDI,
    ST_K_J,
    ST_K_K,
    ST_K_WB,
    ST_P_RD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   slot_ok;

  assign slot_ok = !out_valid_r || !out_stall;

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = rc4_pkg::RD_KEEP;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          if (in_message_start) begin
            state_nxt = ST_K_CLR;
          end else begin
            cmd.rd_sel = rc4_pkg::RD_INC;
            cmd.step_i = 1'b1;
            state_nxt  = ST_RD_J;
          end
        end
      end
      ST_RD_J: begin
        cmd.take_j = 1'b1;
        cmd.rd_sel = rc4_pkg::RD_J;
        state_nxt  = ST_RD_K;
      end
      ST_RD_K: begin
        cmd.take_b = 1'b1;
        cmd.rd_sel = rc4_pkg::RD_K;
        state_nxt  = ST_WB;
      end
      ST_WB: begin
        cmd.wr_j = 1'b1;
        if (slot_ok) begin
          cmd.load_out = 1'b1;
          in_stall     = 1'b0;
          if (in_valid) begin
            cmd.cap_in = 1'b1;
            if (in_message_start) begin
              state_nxt = ST_K_CLR;
            end else begin
              cmd.rd_sel = rc4_pkg::RD_INC;
              cmd.step_i = 1'b1;
              state_nxt  = ST_RD_J;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_K_CLR: begin
        cmd.clr_valid = 1'b1;
        cmd.ksa_init  = 1'b1;
        state_nxt     = ST_K_RDI;
      end
      ST_K_RDI: begin
        cmd.rd_sel = rc4_pkg::RD_INC;
        cmd.step_i = 1'b1;
        state_nxt  = ST_K_J;
      end
      ST_K_J: begin
        cmd.take_j = 1'b1;
        cmd.ksa    = 1'b1;
        cmd.rd_sel = rc4_pkg::RD_J;
        state_nxt  = ST_K_K;
      end
      ST_K_K: begin
        cmd.take_b = 1'b1;
        state_nxt  = ST_K_WB;
      end
      ST_K_WB: begin
        cmd.wr_j = 1'b1;
        if (stat.ksa_last) begin
          cmd.idx_zero = 1'b1;
          state_nxt    = ST_P_RD;
        end else begin
          cmd.rd_sel = rc4_pkg::RD_INC;
          cmd.step_i = 1'b1;
          state_nxt  = ST_K_J;
        end
      end
      ST_P_RD: begin
        cmd.rd_sel = rc4_pkg::RD_INC;
        cmd.step_i = 1'b1;
        state_nxt  = ST_RD_J;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/rc4_stream_cipher.sv
// RC4 stream cipher top level: controller, datapath and permutation memory.
// Each byte takes three dependent reads of the permutation RAM (i, j, keystream) on its one
// read port; the two swap writes overlap them. The next byte is accepted in ST_WB as the output
// register loads; a stalled full output holds ST_WB. A beat with message_start first runs key
// scheduling: ST_K_CLR, ST_K_RDI, 256 swaps through ST_K_J, ST_K_K and ST_K_WB, then ST_P_RD.
// Reset (synchronous, rst_n low) clears all valid bits at once: identity permutation, no sweep.
`include "rc4_stream_cipher_macros.svh"
module rc4_stream_cipher #(
  parameter int MAX_KEY_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_message_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte
);

  rc4_pkg::cmd_t  cmd;
  rc4_pkg::stat_t stat;
  logic           start_beat;
  logic           plain_beat;

  rc4_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_message_start (in_message_start),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .cmd              (cmd),
    .stat             (stat)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_data_byte (in_data_byte),
    .out_byte     (out_byte),
    .cmd          (cmd),
    .stat         (stat)
  );

  assign start_beat = in_valid && !in_stall && in_message_start;
  assign plain_beat = in_valid && !in_stall && !in_message_start;

  `RC4_ASSERT_NXT(a_start_clears, clk, rst_n, start_beat, cmd.clr_valid)
  `RC4_ASSERT_NXT(a_plain_reads_j, clk, rst_n, plain_beat, cmd.take_j && !cmd.ksa)
  `RC4_ASSERT_IMP(a_load_slot_free, clk, rst_n, cmd.load_out, !(out_valid && out_stall))

endmodule

// File: tb/rc4_stream_cipher_tb.sv
// Self-checking testbench for rc4_stream_cipher: directed and random byte streams
// checked against an in-bench keystream predictor. Depends on rc4_pkg and the RTL only.
module rc4_stream_cipher_tb;

  localparam int KEY_MAX     = 16;
  localparam int HOLD_CYCLES = 1000;
  localparam int TAIL_CYCLES = 12;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index = rc4_pkg::CFG_KEY_LOW;
  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_message_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;

  rc4_stream_cipher #(.MAX_KEY_BYTES(KEY_MAX)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_message_start(in_message_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // keystream predictor state
  rc4_pkg::byte_t                 sbox [rc4_pkg::SBOX_DEPTH];
  rc4_pkg::byte_t                 ptr_i;
  rc4_pkg::byte_t                 ptr_j;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_lo;
  logic [rc4_pkg::CFG_DATA_W-1:0] key_hi;
  logic [rc4_pkg::KEY_LEN_W-1:0]  key_len;

  rc4_pkg::byte_t expected_bytes[$];
  rc4_pkg::byte_t got_want;
  int    bad_bytes = 0;
  int    bytes_sent = 0;
  int    bytes_checked = 0;
  int    key_runs = 0;
  int    key_writes = 0;
  int    cycle_count = 0;
  int    src_idle_pct = 0;
  int    snk_idle_pct = 0;
  int    hold_trigger = 0;
  int    hold_ack = 0;
  int    hold_left = 0;

  function automatic rc4_pkg::byte_t key_byte(int unsigned k);
    if (k < 8) return key_lo[8*k +: 8];
    if (k < 16) return key_hi[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  function automatic void identity_sbox();
    int n;
    for (n = 0; n < rc4_pkg::SBOX_DEPTH; n++) sbox[n] = rc4_pkg::byte_t'(n);
  endfunction

  function automatic void schedule_key();
    int unsigned    len;
    int unsigned    k;
    int             n;
    rc4_pkg::byte_t j;
    rc4_pkg::byte_t t;
    len = key_len;
    if (len == 0) len = 1;
    if (len > KEY_MAX) len = KEY_MAX;
    identity_sbox();
    j = 8'h00;
    k = 0;
    for (n = 0; n < rc4_pkg::SBOX_DEPTH; n++) begin
      j = rc4_pkg::byte_t'(j + sbox[n] + key_byte(k));
      t = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
      k = (k + 1 >= len) ? 0 : k + 1;
    end
    ptr_i = 8'h00;
    ptr_j = 8'h00;
  endfunction

  function automatic rc4_pkg::byte_t cipher_byte(rc4_pkg::byte_t data, logic start);
    rc4_pkg::byte_t t;
    if (start) schedule_key();
    ptr_i = rc4_pkg::byte_t'(ptr_i + 8'd1);
    ptr_j = rc4_pkg::byte_t'(ptr_j + sbox[ptr_i]);
    t = sbox[ptr_i];
    sbox[ptr_i] = sbox[ptr_j];
    sbox[ptr_j] = t;
    return data ^ sbox[rc4_pkg::byte_t'(sbox[ptr_i] + sbox[ptr_j])];
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_bytes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_trigger != hold_ack) begin
      hold_ack  <= hold_trigger;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        bad_bytes++;
        if (bad_bytes <= 10)
          $display("Unexpected beat at cycle %0d: out_byte=%02h", cycle_count, out_byte);
      end else begin
        got_want = expected_bytes.pop_front();
        bytes_checked++;
        if (out_byte !== got_want) begin
          bad_bytes++;
          if (bad_bytes <= 10)
            $display("Mismatch at cycle %0d: out_byte expected %02h actual %02h",
                     cycle_count, got_want, out_byte);
        end
      end
    end
  end

  task automatic send_byte(input rc4_pkg::byte_t data, input logic start);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_data_byte     <= data;
    in_message_start <= start;
    do @(posedge clk); while (in_stall);
    expected_bytes.push_back(cipher_byte(data, start));
    bytes_sent++;
    if (start) key_runs++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  task automatic write_cfg(input logic [rc4_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rc4_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      rc4_pkg::CFG_KEY_LOW:  key_lo = data;
      rc4_pkg::CFG_KEY_HIGH: key_hi = data;
      rc4_pkg::CFG_KEY_LEN:  key_len = data[rc4_pkg::KEY_LEN_W-1:0];
      default: ;
    endcase
    key_writes++;
    @(posedge clk);
  endtask

  task automatic set_key(input logic [rc4_pkg::CFG_DATA_W-1:0] lo,
                         input logic [rc4_pkg::CFG_DATA_W-1:0] hi,
                         input logic [rc4_pkg::CFG_DATA_W-1:0] len);
    drain_results();
    write_cfg(rc4_pkg::CFG_KEY_LOW, lo);
    write_cfg(rc4_pkg::CFG_KEY_HIGH, hi);
    write_cfg(rc4_pkg::CFG_KEY_LEN, len);
  endtask

  task automatic test_unkeyed_and_reset_key();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_key_lengths();
    set_key('1, '1, 64'd16);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    set_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 64'd1);
    send_byte(8'h3C, 1'b1);
    send_byte(8'hC3, 1'b0);
    // zero length runs as one byte
    drain_results();
    write_cfg(rc4_pkg::CFG_KEY_LEN, 64'd0);
    send_byte(8'h81, 1'b1);
    send_byte(8'h7E, 1'b0);
    // over-long lengths saturate
    drain_results();
    write_cfg(rc4_pkg::CFG_KEY_LEN, {59'h7FF_FFFF_FFFF_FFFF, 5'd31});
    send_byte(8'h11, 1'b1);
    send_byte(8'hEE, 1'b0);
    drain_results();
    write_cfg(rc4_pkg::CFG_KEY_LEN, 64'd17);
    send_byte(8'h96, 1'b1);
  endtask

  task automatic test_key_change_mid_message();
    set_key(64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908, 64'd5);
    send_byte(8'h10, 1'b1);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    // new key must not disturb the running stream
    set_key(64'hDEAD_BEEF_CAFE_F00D, 64'h1357_9BDF_2468_ACE0, 64'd12);
    send_byte(8'h40, 1'b0);
    send_byte(8'h50, 1'b0);
    send_byte(8'h60, 1'b1);
    send_byte(8'h70, 1'b0);
  endtask

  task automatic test_random_messages(input int src_pct, input int snk_pct, input int n_items);
    int sent;
    int msg_len;
    int b;
    logic [rc4_pkg::KEY_LEN_W-1:0] len;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(9))
          0:       len = 5'd0;
          1:       len = rc4_pkg::KEY_LEN_W'($urandom_range(17, 31));
          default: len = rc4_pkg::KEY_LEN_W'($urandom_range(1, 16));
        endcase
        set_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, 27'($urandom), len});
      end
      msg_len = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (b = 0; b < msg_len; b++)
        send_byte(rc4_pkg::byte_t'($urandom_range(255)), (b == 0) && ($urandom_range(7) != 0));
      sent += msg_len;
    end
  endtask

  task automatic test_backpressure();
    int b;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    drain_results();
    hold_trigger++;
    for (b = 0; b < 24; b++) send_byte(rc4_pkg::byte_t'($urandom_range(255)), b == 0);
    drain_results();
  endtask

  initial begin
    key_lo  = '0;
    key_hi  = '0;
    key_len = rc4_pkg::KEY_LEN_RESET;
    identity_sbox();
    ptr_i = 8'h00;
    ptr_j = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unkeyed_and_reset_key();
    test_key_lengths();
    test_key_change_mid_message();
    test_random_messages(23, 53, 150);
    test_random_messages(53, 23, 150);
    test_backpressure();
    test_random_messages(0, 0, 130);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d bytes over %0d key schedules and %0d register writes; %0d results checked",
             bytes_sent, key_runs, key_writes, bytes_checked);
    $display("Covered unkeyed start, key lengths 0/1/16/17/31, mid-message rekey, long stall");
    if (bad_bytes == 0 && expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", bad_bytes, expected_bytes.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
